>>> design/bts_pkg.sv
`default_nettype none

package bts_pkg;

  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_CHANNEL_BITS = 16;
  localparam int DEF_FRAC_BITS    = 16;

  localparam int POS_W   = 8;
  localparam int CHAN_W  = 16;
  localparam int COORD_W = 17;
  localparam int CFG_W   = 9;
  localparam int SIZE_W  = 9;
  localparam int NUM_BANKS = 4;

  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(256);

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FILTER_MODE  = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic {
    FILTER_NEAREST  = 1'b0,
    FILTER_BILINEAR = 1'b1
  } filter_t;

  typedef struct packed {
    logic               opcode;
    logic [POS_W-1:0]   pixel_x;
    logic [POS_W-1:0]   pixel_y;
    logic [CHAN_W-1:0]  pixel_red;
    logic [CHAN_W-1:0]  pixel_green;
    logic [CHAN_W-1:0]  pixel_blue;
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } result_t;

  // parity of the four footprint texels, picks the bank of each
  typedef struct packed {
    logic x0;
    logic x1;
    logic y0;
    logic y1;
  } bank_sel_t;

endpackage

`default_nettype wire

>>> design/bts_ram.sv
`default_nettype none

module bts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/bts_lerp.sv
`default_nettype none

module bts_lerp #(
  parameter int CB = 16,
  parameter int FB = 16
) (
  input  wire logic          clk,
  input  wire logic [CB-1:0] a,
  input  wire logic [CB-1:0] b,
  input  wire logic [FB-1:0] t,
  output logic      [CB-1:0] y
);

  localparam int PW = CB + FB + 2;

  logic signed [CB:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_q;
  logic        [CB-1:0] a_q;
  logic signed [PW-1:0] shifted;
  logic signed [PW-1:0] total;

  assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
  assign prod = PW'(diff) * PW'($signed({1'b0, t}));

  always_ff @(posedge clk) begin
    prod_q <= prod;
    a_q    <= a;
  end

  // floor division by the weight scale
  assign shifted = prod_q >>> FB;
  assign total   = shifted + $signed({{(FB + 2){1'b0}}, a_q});

  always_ff @(posedge clk) begin
    y <= total[CB-1:0];
  end

endmodule

`default_nettype wire

>>> design/bts_addr.sv
`default_nettype none

module bts_addr
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  localparam int CW  = FRAC_BITS + 1,
  localparam int SWB = $clog2(MAX_WIDTH + 1),
  localparam int SHB = $clog2(MAX_HEIGHT + 1),
  localparam int XB  = $clog2(MAX_WIDTH),
  localparam int YB  = $clog2(MAX_HEIGHT),
  localparam int XHB = (XB > 1) ? XB - 1 : 1,
  localparam int YHB = (YB > 1) ? YB - 1 : 1
) (
  input  wire logic                 clk,
  input  wire logic [CW-1:0]        coord_u,
  input  wire logic [CW-1:0]        coord_v,
  input  wire logic [SWB-1:0]       width_eff,
  input  wire logic [SHB-1:0]       height_eff,
  output logic      [XHB-1:0]       col_even,
  output logic      [XHB-1:0]       col_odd,
  output logic      [YHB-1:0]       row_even,
  output logic      [YHB-1:0]       row_odd,
  output bank_sel_t                 sel,
  output logic      [FRAC_BITS-1:0] tu,
  output logic      [FRAC_BITS-1:0] tv
);

  logic [CW+SWB-1:0] scaled_u;
  logic [CW+SHB-1:0] scaled_v;

  logic [SWB:0]   ipu;
  logic [SHB:0]   ipv;
  logic [SWB-1:0] last_x;
  logic [SHB-1:0] last_y;
  logic [SWB-1:0] x0_s;
  logic [SHB-1:0] y0_s;
  logic [SWB:0]   x0_inc;
  logic [SHB:0]   y0_inc;
  logic [XB-1:0]  x0;
  logic [XB-1:0]  x1;
  logic [YB-1:0]  y0;
  logic [YB-1:0]  y1;
  logic [XB-1:0]  xe;
  logic [XB-1:0]  xo;
  logic [YB-1:0]  ye;
  logic [YB-1:0]  yo;

  always_ff @(posedge clk) begin
    scaled_u <= (CW + SWB)'(coord_u) * (CW + SWB)'(width_eff);
    scaled_v <= (CW + SHB)'(coord_v) * (CW + SHB)'(height_eff);
  end

  assign ipu    = scaled_u[CW+SWB-1:FRAC_BITS];
  assign ipv    = scaled_v[CW+SHB-1:FRAC_BITS];
  assign last_x = width_eff - SWB'(1);
  assign last_y = height_eff - SHB'(1);
  assign x0_s   = (ipu > {1'b0, last_x}) ? last_x : ipu[SWB-1:0];
  assign y0_s   = (ipv > {1'b0, last_y}) ? last_y : ipv[SHB-1:0];
  assign x0_inc = {1'b0, x0_s} + (SWB + 1)'(1);
  assign y0_inc = {1'b0, y0_s} + (SHB + 1)'(1);
  assign x0     = x0_s[XB-1:0];
  assign y0     = y0_s[YB-1:0];
  assign x1     = (x0_inc < {1'b0, width_eff}) ? x0_inc[XB-1:0] : x0;
  assign y1     = (y0_inc < {1'b0, height_eff}) ? y0_inc[YB-1:0] : y0;

  assign xe = x0[0] ? x1 : x0;
  assign xo = x0[0] ? x0 : x1;
  assign ye = y0[0] ? y1 : y0;
  assign yo = y0[0] ? y0 : y1;

  assign col_even = XHB'(xe >> 1);
  assign col_odd  = XHB'(xo >> 1);
  assign row_even = YHB'(ye >> 1);
  assign row_odd  = YHB'(yo >> 1);

  assign sel.x0 = x0[0];
  assign sel.x1 = x1[0];
  assign sel.y0 = y0[0];
  assign sel.y1 = y1[0];

  assign tu = scaled_u[FRAC_BITS-1:0];
  assign tv = scaled_v[FRAC_BITS-1:0];

endmodule

`default_nettype wire

>>> design/bilinear_texture_sampler.sv
`default_nettype none

// bilinear texture sampler
// items enter on start with the item struct; busy is always low, so an item
// may be issued every cycle. a load item writes one pixel of the image, if
// that pixel lies inside the image size, and gives no result; a sample item
// gives one result on the result struct, marked by done for exactly one cycle.
// the receiver cannot stall, and none of the stages waits.
// throughput is one item per cycle: the pixel store is split into four banks
// by column and row parity, so the four texels of a footprint are read in the
// same cycle, and the two blend steps each take a two-stage multiply-add.
// configuration (width, height, filter mode) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while no item is in
// flight, as the block itself does not enforce this. reset empties the
// pipeline and sets the size to 256 by 256 and the filter to bilinear; the
// pixel store is not cleared and must be loaded before a sample reads it.

module bilinear_texture_sampler
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire item_t            item,
  output logic                  done,
  output result_t               result,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int CB    = CHANNEL_BITS;
  localparam int CW    = FRAC_BITS + 1;
  localparam int SWB   = $clog2(MAX_WIDTH + 1);
  localparam int SHB   = $clog2(MAX_HEIGHT + 1);
  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);
  localparam int XHB   = (XB > 1) ? XB - 1 : 1;
  localparam int YHB   = (YB > 1) ? YB - 1 : 1;
  localparam int AW    = XHB + YHB;
  localparam int DEPTH = 2 ** AW;
  localparam int DW    = 3 * CB;

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic              filter_mode;

  logic [SWB-1:0] width_eff;
  logic [SHB-1:0] height_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_SIZE;
      image_height <= RESET_SIZE;
      filter_mode  <= FILTER_BILINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[SIZE_W-1:0];
        CFG_FILTER_MODE:  filter_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      width_eff = SWB'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_eff = SWB'(MAX_WIDTH);
    end else begin
      width_eff = SWB'(image_width);
    end
    if (image_height == '0) begin
      height_eff = SHB'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      height_eff = SHB'(MAX_HEIGHT);
    end else begin
      height_eff = SHB'(image_height);
    end
  end

  assign busy = 1'b0;

  // stage 1: input register
  logic          v1_load;
  logic          v1_sample;
  item_t         item1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_load   <= 1'b0;
      v1_sample <= 1'b0;
    end else begin
      v1_load   <= start && (item.opcode == OP_LOAD);
      v1_sample <= start && (item.opcode == OP_SAMPLE);
    end
    item1 <= item;
  end

  logic [31:0] wx1;
  logic [31:0] wy1;
  logic        in_image1;

  assign wx1       = {{(32 - POS_W){1'b0}}, item1.pixel_x};
  assign wy1       = {{(32 - POS_W){1'b0}}, item1.pixel_y};
  assign in_image1 = (wx1 < 32'(width_eff)) && (wy1 < 32'(height_eff));

  // stage 2: scaled coordinates, write held back to line up with reads
  logic           v2_write;
  logic           v2_sample;
  logic [XB-1:0]  wx2;
  logic [YB-1:0]  wy2;
  logic [DW-1:0]  wdata2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2_write  <= 1'b0;
      v2_sample <= 1'b0;
    end else begin
      v2_write  <= v1_load && in_image1;
      v2_sample <= v1_sample;
    end
    wx2    <= wx1[XB-1:0];
    wy2    <= wy1[YB-1:0];
    wdata2 <= {CB'(item1.pixel_red), CB'(item1.pixel_green), CB'(item1.pixel_blue)};
  end

  logic [XHB-1:0]       col_even;
  logic [XHB-1:0]       col_odd;
  logic [YHB-1:0]       row_even;
  logic [YHB-1:0]       row_odd;
  bank_sel_t            sel2;
  logic [FRAC_BITS-1:0] tu2;
  logic [FRAC_BITS-1:0] tv2;

  bts_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_addr (
    .clk        (clk),
    .coord_u    (CW'(item1.coord_u)),
    .coord_v    (CW'(item1.coord_v)),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .col_even   (col_even),
    .col_odd    (col_odd),
    .row_even   (row_even),
    .row_odd    (row_odd),
    .sel        (sel2),
    .tu         (tu2),
    .tv         (tv2)
  );

  logic [XHB-1:0] wcol2;
  logic [YHB-1:0] wrow2;
  logic [AW-1:0]  waddr2;

  assign wcol2  = XHB'(wx2 >> 1);
  assign wrow2  = YHB'(wy2 >> 1);
  assign waddr2 = {wrow2, wcol2};

  logic [DW-1:0] bank_q [NUM_BANKS];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [AW-1:0] raddr;
    logic          we;

    assign raddr = {(b / 2 == 1) ? row_odd : row_even, (b % 2 == 1) ? col_odd : col_even};
    assign we    = v2_write && (wy2[0] == 1'((b / 2) % 2)) && (wx2[0] == 1'(b % 2));

    bts_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr2),
      .wdata (wdata2),
      .raddr (raddr),
      .rdata (bank_q[b])
    );
  end

  // stage 3: bank data out, weights forced to zero for nearest
  logic                 v3;
  bank_sel_t            sel3;
  logic [FRAC_BITS-1:0] tu3;
  logic [FRAC_BITS-1:0] tv3;
  logic [FRAC_BITS-1:0] tv4;
  logic [FRAC_BITS-1:0] tv5;
  logic                 v4;
  logic                 v5;
  logic                 v6;
  logic                 v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v3 <= v2_sample;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
    sel3 <= sel2;
    tu3  <= (filter_mode == FILTER_BILINEAR) ? tu2 : '0;
    tv3  <= (filter_mode == FILTER_BILINEAR) ? tv2 : '0;
    tv4  <= tv3;
    tv5  <= tv4;
  end

  logic [DW-1:0] t00;
  logic [DW-1:0] t10;
  logic [DW-1:0] t01;
  logic [DW-1:0] t11;

  assign t00 = bank_q[{sel3.y0, sel3.x0}];
  assign t10 = bank_q[{sel3.y0, sel3.x1}];
  assign t01 = bank_q[{sel3.y1, sel3.x0}];
  assign t11 = bank_q[{sel3.y1, sel3.x1}];

  logic [CB-1:0] chan_out [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [CB-1:0] top;
    logic [CB-1:0] bot;

    bts_lerp #(.CB(CB), .FB(FRAC_BITS)) u_top (
      .clk (clk),
      .a   (t00[DW-1-c*CB -: CB]),
      .b   (t10[DW-1-c*CB -: CB]),
      .t   (tu3),
      .y   (top)
    );

    bts_lerp #(.CB(CB), .FB(FRAC_BITS)) u_bot (
      .clk (clk),
      .a   (t01[DW-1-c*CB -: CB]),
      .b   (t11[DW-1-c*CB -: CB]),
      .t   (tu3),
      .y   (bot)
    );

    bts_lerp #(.CB(CB), .FB(FRAC_BITS)) u_vert (
      .clk (clk),
      .a   (top),
      .b   (bot),
      .t   (tv5),
      .y   (chan_out[c])
    );
  end

  assign done             = v7;
  assign result.out_red   = CHAN_W'(chan_out[0]);
  assign result.out_green = CHAN_W'(chan_out[1]);
  assign result.out_blue  = CHAN_W'(chan_out[2]);

endmodule

`default_nettype wire

>>> tb/bilinear_texture_sampler_tb.sv
`default_nettype none

module bilinear_texture_sampler_tb;
  import bts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  item_t            item;
  logic             done;
  result_t          result;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bilinear_texture_sampler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // texture model
  logic [47:0]   texels [0:65535];
  bit            texel_valid [0:65535];
  logic [8:0]    width_reg;
  logic [8:0]    height_reg;
  filter_t       mode_reg;
  result_t       pending_samples [$];
  int            idle_pct;
  int            errors;
  int            n_loads;
  int            n_samples;
  int            n_checked;
  int            n_cfg;
  logic          busy_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("bilinear_texture_sampler_tb failed");
    $finish;
  end

  function automatic int eff_size(logic [8:0] r);
    if (r == 0) return 1;
    if (r > 256) return 256;
    return int'(r);
  endfunction

  function automatic void split(logic [16:0] c, int sz, output int idx,
                                output longint frac);
    longint scaled;
    longint ip;
    scaled = longint'(c) * sz;
    ip = scaled >> 16;
    if (ip > sz - 1) ip = sz - 1;
    idx = int'(ip);
    frac = scaled & 64'hFFFF;
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    if (b >= a) return a + (((b - a) * t) >> 16);
    return a - ((((a - b) * t) + 64'hFFFF) >> 16);
  endfunction

  function automatic longint chan(int x, int y, int ch);
    logic [47:0] p;
    p = texels[y * 256 + x];
    return longint'(p[47 - 16 * ch -: 16]);
  endfunction

  function automatic result_t filter_texture(item_t it);
    int x0, y0, x1, y1, w, h;
    longint tu, tv, top, bot;
    longint r [3];
    result_t res;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    split(it.coord_u, w, x0, tu);
    split(it.coord_v, h, y0, tv);
    x1 = (x0 + 1 < w) ? x0 + 1 : x0;
    y1 = (y0 + 1 < h) ? y0 + 1 : y0;
    for (int ch = 0; ch < 3; ch++) begin
      if (mode_reg == FILTER_NEAREST) begin
        r[ch] = chan(x0, y0, ch);
      end else begin
        top = lerp(chan(x0, y0, ch), chan(x1, y0, ch), tu);
        bot = lerp(chan(x0, y1, ch), chan(x1, y1, ch), tu);
        r[ch] = lerp(top, bot, tv);
      end
    end
    res.out_red = r[0][15:0];
    res.out_green = r[1][15:0];
    res.out_blue = r[2][15:0];
    return res;
  endfunction

  function automatic void apply_item(item_t it);
    int idx;
    if (it.opcode == OP_LOAD) begin
      n_loads++;
      if (it.pixel_x < eff_size(width_reg) && it.pixel_y < eff_size(height_reg)) begin
        idx = int'(it.pixel_y) * 256 + int'(it.pixel_x);
        texels[idx] = {it.pixel_red, it.pixel_green, it.pixel_blue};
        texel_valid[idx] = 1'b1;
      end
    end else begin
      n_samples++;
      pending_samples.push_back(filter_texture(it));
    end
  endfunction

  always @(negedge clk) busy_seen <= busy;

  always @(negedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, result);
      end else begin
        exp_r = pending_samples.pop_front();
        n_checked++;
        if (result.out_red !== exp_r.out_red) begin
          errors++;
          $display("%0t: red expected %h actual %h", $time, exp_r.out_red, result.out_red);
        end
        if (result.out_green !== exp_r.out_green) begin
          errors++;
          $display("%0t: green expected %h actual %h", $time, exp_r.out_green,
                   result.out_green);
        end
        if (result.out_blue !== exp_r.out_blue) begin
          errors++;
          $display("%0t: blue expected %h actual %h", $time, exp_r.out_blue,
                   result.out_blue);
        end
      end
    end
  end

  task automatic send_item(item_t it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy_seen);
    apply_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_IMAGE_WIDTH: width_reg = val;
      CFG_IMAGE_HEIGHT: height_reg = val;
      default: mode_reg = filter_t'(val[0]);
    endcase
  endtask

  task automatic set_image(logic [8:0] w, logic [8:0] h, filter_t m);
    write_cfg(CFG_IMAGE_WIDTH, w);
    write_cfg(CFG_IMAGE_HEIGHT, h);
    write_cfg(CFG_FILTER_MODE, CFG_W'(m));
  endtask

  function automatic item_t noise_item();
    item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  task automatic load_pixel(int x, int y, logic [47:0] rgb);
    item_t it;
    it = noise_item();
    it.opcode = OP_LOAD;
    it.pixel_x = x[7:0];
    it.pixel_y = y[7:0];
    {it.pixel_red, it.pixel_green, it.pixel_blue} = rgb;
    send_item(it);
  endtask

  function automatic logic [47:0] rand_rgb();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // loads any unwritten texel of the footprint, then samples
  task automatic sample_at(logic [16:0] u, logic [16:0] v);
    int x0, y0, w, h;
    longint f;
    item_t it;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    split(u, w, x0, f);
    split(v, h, y0, f);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        if (x0 + dx < w && y0 + dy < h && !texel_valid[(y0 + dy) * 256 + x0 + dx])
          load_pixel(x0 + dx, y0 + dy, rand_rgb());
      end
    end
    it = noise_item();
    it.opcode = OP_SAMPLE;
    it.coord_u = u;
    it.coord_v = v;
    send_item(it);
  endtask

  function automatic logic [16:0] rand_coord();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom);
      3: return 17'($urandom_range(65535));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic random_traffic(int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: begin
          it = noise_item();
          it.opcode = OP_LOAD;
          send_item(it);
        end
        2: load_pixel($urandom_range(eff_size(width_reg) - 1),
                      $urandom_range(eff_size(height_reg) - 1), rand_rgb());
        default: sample_at(rand_coord(), rand_coord());
      endcase
    end
  endtask

  task automatic test_edges();
    set_image(9'd4, 9'd4, FILTER_BILINEAR);
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++)
        load_pixel(x, y, ((x + y) % 2) ? 48'hFFFF_FFFF_FFFF : 48'h0);
    load_pixel(4, 0, 48'h1234_5678_9ABC);
    load_pixel(0, 255, 48'h1234_5678_9ABC);
    sample_at(17'd0, 17'd0);
    sample_at(17'd32768, 17'd32768);
    sample_at(17'd65535, 17'd65535);
    sample_at(17'd65536, 17'd65536);
    sample_at(17'h1FFFF, 17'd100);
    sample_at(17'd12345, 17'h1FFFF);
    write_cfg(CFG_FILTER_MODE, CFG_W'(FILTER_NEAREST));
    sample_at(17'd49151, 17'd16384);
    sample_at(17'd65536, 17'd0);
    set_image(9'd0, 9'd0, FILTER_BILINEAR);
    sample_at(17'd40000, 17'd65536);
    set_image(9'd511, 9'd256, FILTER_BILINEAR);
    sample_at(17'd65536, 17'd65536);
    sample_at(17'd0, 17'd65535);
  endtask

  task automatic test_sizes();
    logic [8:0] ws [6] = '{9'd1, 9'd256, 9'd2, 9'd511, 9'd0, 9'd7};
    logic [8:0] hs [6] = '{9'd256, 9'd1, 9'd3, 9'd300, 9'd2, 9'd16};
    int phase_idle [4] = '{0, 77, 0, 28};
    for (int p = 0; p < 12; p++) begin
      idle_pct = phase_idle[p % 4];
      if (p < 6) set_image(ws[p], hs[p], filter_t'(p % 2));
      else set_image(9'($urandom_range(1, 40)), 9'($urandom_range(1, 40)),
                     filter_t'($urandom_range(1)));
      random_traffic(16);
    end
  endtask

  task automatic test_pause();
    idle_pct = 0;
    set_image(9'($urandom), 9'($urandom), FILTER_BILINEAR);
    random_traffic(20);
    drain();
    random_traffic(20);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    mode_reg = FILTER_BILINEAR;
    idle_pct = 0;
    errors = 0;
    n_loads = 0;
    n_samples = 0;
    n_checked = 0;
    n_cfg = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_sizes();
    test_pause();
    drain();
    $display("covered %0d loads, %0d samples (%0d checked), %0d register writes",
             n_loads, n_samples, n_checked, n_cfg);
    $display("both filters, image sizes from 1 to 256 with saturated size values");
    if (errors == 0) begin
      $display("bilinear_texture_sampler_tb passed");
    end else begin
      $display("bilinear_texture_sampler_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/bts_pkg.sv
design/bts_ram.sv
design/bts_lerp.sv
design/bts_addr.sv
design/bilinear_texture_sampler.sv
tb/bilinear_texture_sampler_tb.sv
